### rtl/lpht_pkg.sv
// Package for the linear probing hash table: shared types, codes and widths.
// No dependencies; imported by every module of the block but lpht_ram.
`timescale 1ns / 1ps

package lpht_pkg;

  localparam int unsigned KEY_W     = 31;
  localparam int unsigned DIV_W     = KEY_W + 1;   // dividend, padded to even width
  localparam int unsigned SIZE_W    = 5;
  localparam int unsigned SLOT_W    = 5;           // slots stay below 31
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned MOD_STEPS = DIV_W / 2;   // two quotient bits per cycle
  localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_SIZE   = 1'b0,
    REG_REPLACE_MODE = 1'b1
  } lpht_reg_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } lpht_action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_CLEARED   = 3'd4
  } lpht_status_e;

  typedef enum logic [1:0] {
    SLOT_ZERO,
    SLOT_PTR,
    SLOT_HOME,
    SLOT_EMPTY
  } lpht_slot_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MOD_KEY,
    S_SCAN,
    S_RKEY,
    S_RLOAD,
    S_RMOD,
    S_WMOVE,
    S_SRD,
    S_SCMP,
    S_DONE
  } lpht_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic           accept;
    logic           mod_load_key;
    logic           mod_load_ram;
    logic           mod_step;
    logic           set_home;
    logic           probe_step;
    logic           latch_empty;
    logic           ram_rd;
    lpht_slot_sel_e rd_sel;
    logic           ram_wr;
    lpht_slot_sel_e wr_sel;
    logic           wr_moved;
    logic           clear_used;
    logic           res_load;
    lpht_status_e   res_status;
    lpht_slot_sel_e res_pos_sel;
    logic           out_push;
  } lpht_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    lpht_action_e action;
    logic         replace;
    logic         mod_last;
    logic         used_ptr;
    logic         probe_first;
    logic         probe_last;
    logic         key_match;
    logic         own_home;
    logic         out_free;
  } lpht_stat_t;

endpackage

### rtl/linear_probe_hash_table_core.sv
// Top level of the open-addressed, linearly probed hash table.
// Depends on lpht_pkg, lpht_ctrl, lpht_datapath (and lpht_ram below it).
//
// Usage
//   Input channel (in_valid_i / in_stall_o, action_i, key_i): one request
//   per item: insert, search or clear. The block works on one request at a
//   time; in_stall_o is low only when no request is in flight.
//   Output channel (out_valid_o / out_stall_i, status_o, position_o): one
//   result per request, in order. The result sits in an output register,
//   so a new request is taken while an earlier result still waits.
//   Config port (cfg_we_i, cfg_idx_i, cfg_data_i): index 0 table size,
//   index 1 replacement mode; write only while the block is idle.
// Sequence (n = effective table size)
//   Home slot = key mod n from a remainder unit retiring two bits a cycle.
//   Insert probes on from the home slot; a replacement adds a read and a new
//   reduction of the key in the home slot, and a write when that key has to move.
//   Search: each probe is a key RAM read plus a compare. Clear and unused actions go from decode straight to done.
//   The next request is taken the cycle after the result moves to the
//   output register.
// Reset
//   Table empty, size 16, replacement off, no result pending. Keys in the
//   RAM are not cleared; empty slots are never read.
// Stall
//   A held result keeps the block in its final state until the output
//   register frees up; nothing is lost or repeated.
`timescale 1ns / 1ps

module linear_probe_hash_table_core
  import lpht_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ACTION_W-1:0]  action_i,
  input  logic [KEY_W-1:0]     key_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [POS_W-1:0]     position_o
);

  lpht_cmd_t  cmd;
  lpht_stat_t stat;

  // Sequencer: one request at a time
  lpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Storage, remainder unit and output register
  lpht_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .action_i    (action_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .position_o  (position_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  // A taken request closes the input until its result is handed off
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while another is in flight");

  // Never overwrite a result the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_push |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten while stalled");

  // Results with no slot report position zero
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL || status_o == ST_NOT_FOUND ||
                     status_o == ST_CLEARED)) |-> (position_o == '0))
    else $error("nonzero position on a result without a slot");

  // Push only happens from the final state, which holds the input closed
  a_push_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_push |-> in_stall_o)
    else $error("result pushed while the input was open");

endmodule

### rtl/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lpht_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lpht_ctrl.sv
// Controller state machine for the hash table: sequences modulo, probing,
// key store accesses and result hand-off. Depends on lpht_pkg.
`timescale 1ns / 1ps

module lpht_ctrl
  import lpht_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  lpht_stat_t stat_i,
  output lpht_cmd_t  cmd_o
);

  lpht_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat_i.action)
          ACT_INSERT, ACT_SEARCH: state_d = S_MOD_KEY;
          ACT_CLEAR, ACT_NONE:    state_d = S_DONE;
          default:                state_d = S_DONE;
        endcase
      end
      S_MOD_KEY: begin
        if (stat_i.mod_last) begin
          state_d = (stat_i.action == ACT_INSERT) ? S_SCAN : S_SRD;
        end
      end
      S_SCAN: begin
        priority if (!stat_i.used_ptr) begin
          state_d = (!stat_i.replace || stat_i.probe_first) ? S_DONE : S_RKEY;
        end else if (stat_i.probe_last) begin
          state_d = S_DONE;
        end
      end
      S_RKEY:  state_d = S_RLOAD;
      S_RLOAD: state_d = S_RMOD;
      S_RMOD: begin
        if (stat_i.mod_last) state_d = stat_i.own_home ? S_DONE : S_WMOVE;
      end
      S_WMOVE: state_d = S_DONE;
      S_SRD:   state_d = stat_i.used_ptr ? S_SCMP : S_DONE;
      S_SCMP: begin
        state_d = (stat_i.key_match || stat_i.probe_last) ? S_DONE : S_SRD;
      end
      S_DONE: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: cmd_o.accept = in_valid_i;
      S_DECODE: begin
        unique case (stat_i.action)
          ACT_INSERT, ACT_SEARCH: cmd_o.mod_load_key = 1'b1;
          ACT_CLEAR: begin
            cmd_o.clear_used  = 1'b1;
            cmd_o.res_load    = 1'b1;
            cmd_o.res_status  = ST_CLEARED;
            cmd_o.res_pos_sel = SLOT_ZERO;
          end
          default: begin
            cmd_o.res_load    = 1'b1;
            cmd_o.res_status  = ST_NOT_FOUND;
            cmd_o.res_pos_sel = SLOT_ZERO;
          end
        endcase
      end
      S_MOD_KEY: begin
        cmd_o.mod_step = 1'b1;
        cmd_o.set_home = stat_i.mod_last;
      end
      S_SCAN: begin
        priority if (!stat_i.used_ptr) begin
          if (!stat_i.replace || stat_i.probe_first) begin
            cmd_o.ram_wr      = 1'b1;
            cmd_o.wr_sel      = SLOT_PTR;
            cmd_o.res_load    = 1'b1;
            cmd_o.res_status  = ST_INSERTED;
            cmd_o.res_pos_sel = SLOT_PTR;
          end else begin
            cmd_o.latch_empty = 1'b1;
          end
        end else if (stat_i.probe_last) begin
          cmd_o.res_load    = 1'b1;
          cmd_o.res_status  = ST_FULL;
          cmd_o.res_pos_sel = SLOT_ZERO;
        end else begin
          cmd_o.probe_step = 1'b1;
        end
      end
      S_RKEY: begin
        cmd_o.ram_rd = 1'b1;
        cmd_o.rd_sel = SLOT_HOME;
      end
      S_RLOAD: cmd_o.mod_load_ram = 1'b1;
      S_RMOD: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_last) begin
          cmd_o.ram_wr     = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_INSERTED;
          if (stat_i.own_home) begin
            cmd_o.wr_sel      = SLOT_EMPTY;
            cmd_o.res_pos_sel = SLOT_EMPTY;
          end else begin
            cmd_o.wr_sel      = SLOT_HOME;
            cmd_o.res_pos_sel = SLOT_HOME;
          end
        end
      end
      S_WMOVE: begin
        cmd_o.ram_wr   = 1'b1;
        cmd_o.wr_sel   = SLOT_EMPTY;
        cmd_o.wr_moved = 1'b1;
      end
      S_SRD: begin
        if (stat_i.used_ptr) begin
          cmd_o.ram_rd = 1'b1;
          cmd_o.rd_sel = SLOT_PTR;
        end else begin
          cmd_o.res_load    = 1'b1;
          cmd_o.res_status  = ST_NOT_FOUND;
          cmd_o.res_pos_sel = SLOT_ZERO;
        end
      end
      S_SCMP: begin
        priority if (stat_i.key_match) begin
          cmd_o.res_load    = 1'b1;
          cmd_o.res_status  = ST_FOUND;
          cmd_o.res_pos_sel = SLOT_PTR;
        end else if (stat_i.probe_last) begin
          cmd_o.res_load    = 1'b1;
          cmd_o.res_status  = ST_NOT_FOUND;
          cmd_o.res_pos_sel = SLOT_ZERO;
        end else begin
          cmd_o.probe_step = 1'b1;
        end
      end
      S_DONE: cmd_o.out_push = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

### rtl/lpht_datapath.sv
// Datapath of the hash table: config registers, remainder unit, probe
// pointer, occupancy bits, key store RAM and output register.
// Depends on lpht_pkg and lpht_ram.
`timescale 1ns / 1ps

module lpht_datapath
  import lpht_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [ACTION_W-1:0]  action_i,
  input  logic [KEY_W-1:0]     key_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [POS_W-1:0]     position_o,
  input  lpht_cmd_t            cmd_i,
  output lpht_stat_t           stat_o
);

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned N_CAP  = (TABLE_DEPTH > 31) ? 31 : TABLE_DEPTH;
  localparam int unsigned UIDX_W = $clog2(N_CAP);
  localparam logic [SIZE_W-1:0] N_CAP_V = SIZE_W'(N_CAP);

  // Configuration
  logic [SIZE_W-1:0] table_size_q;
  logic              replace_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TABLE_SIZE_RST;
      replace_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (lpht_reg_e'(cfg_idx_i))
        REG_TABLE_SIZE:   table_size_q <= cfg_data_i[SIZE_W-1:0];
        REG_REPLACE_MODE: replace_q    <= cfg_data_i[0];
        default:          replace_q    <= replace_q;
      endcase
    end
  end

  logic [SIZE_W-1:0] n_eff;
  assign n_eff = (table_size_q == '0)   ? SIZE_W'(1) :
                 (table_size_q > N_CAP_V) ? N_CAP_V : table_size_q;

  // Request payload
  lpht_action_e      action_q;
  logic [KEY_W-1:0]  key_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= lpht_action_e'(action_i);
      key_q    <= key_i;
    end
  end

  // Remainder unit: two restoring steps per cycle
  logic [DIV_W-1:0]     div_q;
  logic [SLOT_W-1:0]    rem_q, rem_nxt;
  logic [MOD_CNT_W-1:0] mod_cnt_q;
  logic [KEY_W-1:0]     moved_q;
  logic [KEY_W-1:0]     ram_rdata;
  logic [SLOT_W:0]      t1, t2, r1;

  always_comb begin
    t1      = {rem_q, div_q[DIV_W-1]};
    r1      = (t1 >= {1'b0, n_eff}) ? (t1 - {1'b0, n_eff}) : t1;
    t2      = {r1[SLOT_W-1:0], div_q[DIV_W-2]};
    rem_nxt = (t2 >= {1'b0, n_eff}) ? SLOT_W'(t2 - {1'b0, n_eff}) : t2[SLOT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_load_key || cmd_i.mod_load_ram) begin
      div_q     <= cmd_i.mod_load_ram ? {1'b0, ram_rdata} : {1'b0, key_q};
      rem_q     <= '0;
      mod_cnt_q <= '0;
    end else if (cmd_i.mod_step) begin
      div_q     <= {div_q[DIV_W-3:0], 2'b00};
      rem_q     <= rem_nxt;
      mod_cnt_q <= mod_cnt_q + MOD_CNT_W'(1);
    end
    if (cmd_i.mod_load_ram) begin
      moved_q <= ram_rdata;
    end
  end

  // Probe pointer
  logic [SLOT_W-1:0] home_q, ptr_q, cnt_q, empty_q;
  logic [SLOT_W:0]   ptr_inc;

  assign ptr_inc = {1'b0, ptr_q} + (SLOT_W + 1)'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_home) begin
      home_q <= rem_nxt;
      ptr_q  <= rem_nxt;
      cnt_q  <= '0;
    end else if (cmd_i.probe_step) begin
      ptr_q  <= (ptr_inc >= {1'b0, n_eff}) ? '0 : ptr_inc[SLOT_W-1:0];
      cnt_q  <= cnt_q + SLOT_W'(1);
    end
    if (cmd_i.latch_empty) begin
      empty_q <= ptr_q;
    end
  end

  function automatic logic [SLOT_W-1:0] pick_slot(
    input lpht_slot_sel_e   sel,
    input logic [SLOT_W-1:0] ptr,
    input logic [SLOT_W-1:0] home,
    input logic [SLOT_W-1:0] empty
  );
    logic [SLOT_W-1:0] s;
    unique case (sel)
      SLOT_PTR:   s = ptr;
      SLOT_HOME:  s = home;
      SLOT_EMPTY: s = empty;
      default:    s = '0;
    endcase
    return s;
  endfunction

  logic [SLOT_W-1:0] wr_slot, rd_slot, res_slot;
  assign wr_slot  = pick_slot(cmd_i.wr_sel, ptr_q, home_q, empty_q);
  assign rd_slot  = pick_slot(cmd_i.rd_sel, ptr_q, home_q, empty_q);
  assign res_slot = pick_slot(cmd_i.res_pos_sel, ptr_q, home_q, empty_q);

  // Occupancy bits
  logic [N_CAP-1:0] used_q, used_d;

  always_comb begin
    used_d = used_q;
    if (cmd_i.clear_used) used_d = '0;
    if (cmd_i.ram_wr) used_d[UIDX_W'(wr_slot)] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  // Key store
  lpht_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_wr),
    .waddr_i (IDX_W'(wr_slot)),
    .wdata_i (cmd_i.wr_moved ? moved_q : key_q),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (IDX_W'(rd_slot)),
    .rdata_o (ram_rdata)
  );

  // Result and output register
  lpht_status_e     res_status_q;
  logic [POS_W-1:0] res_pos_q;
  logic             out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [POS_W-1:0] pos_q;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_pos_q    <= res_slot[POS_W-1:0];
    end
    if (cmd_i.out_push) begin
      status_q <= res_status_q;
      pos_q    <= res_pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign position_o  = pos_q;

  // Status to controller
  always_comb begin
    stat_o             = '0;
    stat_o.action      = action_q;
    stat_o.replace     = replace_q;
    stat_o.mod_last    = (mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1));
    stat_o.used_ptr    = used_q[UIDX_W'(ptr_q)];
    stat_o.probe_first = (cnt_q == '0);
    stat_o.probe_last  = (cnt_q == n_eff - SLOT_W'(1));
    stat_o.key_match   = (ram_rdata == key_q);
    stat_o.own_home    = (rem_nxt == home_q);
    stat_o.out_free    = out_free;
  end

endmodule
